// File: rtl/cwa_pkg.sv
// Shared types, constants and the exp lookup table for the windowed attention block.
// Used by cwa_ctrl, cwa_dp and causal_window_attention; depends on nothing else.
package cwa_pkg;

	localparam int MAX_ROWS        = 512;
	localparam int MAX_HEAD_DIM    = 64;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_STEP_SHIFT  = 8;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int DIM_W  = $clog2(MAX_HEAD_DIM);
	localparam int KV_AW  = ROW_W + DIM_W;
	localparam int CNT_W  = ROW_W + 1;
	localparam int HD_W   = 7;
	localparam int BAND_W = 9;
	localparam int TBL_AW = $clog2(EXP_TABLE_DEPTH);
	localparam int SUM_W  = 16 + ROW_W;
	localparam int ACC_W  = 33 + ROW_W;
	localparam int RCP_W  = 17;

	localparam logic [63:0] EXP_RATIO_Q32 = 64'd4034743495;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_HEAD_DIM = 2'd0;
	localparam logic [1:0] REG_BAND     = 2'd1;
	localparam logic [1:0] REG_SCALE    = 2'd2;

	typedef struct packed {
		logic signed [15:0] q_value;
		logic signed [15:0] k_value;
		logic signed [15:0] v_value;
		logic               last_element;
		logic               new_sequence;
	} cwa_in_t;

	typedef struct packed {
		logic signed [15:0] out_value;
		logic [5:0]         out_index;
		logic               last_result;
	} cwa_out_t;

	typedef enum logic [1:0] {
		OP_DOT,
		OP_EXP,
		OP_WGT,
		OP_OUT
	} cwa_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT_RUN,
		ST_DOT_WAIT,
		ST_EXP_RUN,
		ST_EXP_WAIT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_WGT_RUN,
		ST_WGT_WAIT,
		ST_OUT_RUN,
		ST_OUT_WAIT,
		ST_OUT_HOLD
	} cwa_state_t;

	typedef struct packed {
		logic                ld_we;
		logic [KV_AW-1:0]    ld_kv_addr;
		logic [DIM_W-1:0]    ld_q_addr;
		logic [KV_AW-1:0]    rd_kv_addr;
		logic [DIM_W-1:0]    rd_q_addr;
		logic [ROW_W-1:0]    rd_scr_addr;
		logic                issue;
		cwa_op_t             op;
		logic                first;
		logic                last;
		logic [ROW_W-1:0]    idx;
		logic [DIM_W-1:0]    dim;
		logic                dim_last;
		logic                div_start;
	} cwa_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} cwa_status_t;

	typedef logic [15:0] exp_table_t [EXP_TABLE_DEPTH];

	// exp(-i/16) in Q0.16, built by repeated rounded multiplication.
	function automatic exp_table_t build_exp_table();
		exp_table_t  tbl;
		logic [95:0] run;
		logic [95:0] ent;
		run = 96'd1 << 32;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			ent = (run + 96'd32768) >> 16;
			tbl[i] = (ent > 96'd65535) ? 16'hFFFF : ent[15:0];
			run = (run * {32'd0, EXP_RATIO_Q32} + 96'd2147483648) >> 32;
		end
		return tbl;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// File: rtl/cwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module cwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/cwa_ctrl.sv
// Controller: row bookkeeping, ring pointers and the phase sequencer.
// Depends on cwa_pkg; drives the datapath through cwa_cmd_t.
module cwa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       last_element,
	input  logic                       new_sequence,
	input  logic [cwa_pkg::HD_W-1:0]   head_dim_used,
	input  logic [cwa_pkg::BAND_W-1:0] window_band,
	output cwa_pkg::cwa_cmd_t          cmd,
	input  cwa_pkg::cwa_status_t       status
);
	import cwa_pkg::*;

	cwa_state_t        state_q, state_nx;
	logic [DIM_W-1:0]  elem_q;
	logic [ROW_W-1:0]  wp_q;
	logic [CNT_W-1:0]  held_q;
	logic [ROW_W-1:0]  slot_q;
	logic [HD_W-1:0]   dlen_q;
	logic [CNT_W-1:0]  win_q;
	logic [ROW_W-1:0]  j_q;
	logic [DIM_W-1:0]  d_q;

	logic [HD_W-1:0]   hd_eff;
	logic [DIM_W-1:0]  elem_base;
	logic [HD_W-1:0]   e7;
	logic              row_end;
	logic [ROW_W-1:0]  wp_base;
	logic [CNT_W-1:0]  held_base;
	logic [CNT_W-1:0]  held_next;
	logic [CNT_W-1:0]  band_win;
	logic [CNT_W-1:0]  win_next;
	logic              accept;
	logic              j_last;
	logic              d_last;
	logic [ROW_W-1:0]  row_sel;

	always_comb begin
		if (head_dim_used == '0) begin
			hd_eff = HD_W'(1);
		end else if (head_dim_used > HD_W'(MAX_HEAD_DIM)) begin
			hd_eff = HD_W'(MAX_HEAD_DIM);
		end else begin
			hd_eff = head_dim_used;
		end
	end

	assign elem_base = new_sequence ? '0 : elem_q;
	assign e7        = ({1'b0, elem_base} >= hd_eff) ? hd_eff - HD_W'(1) : {1'b0, elem_base};
	assign row_end   = last_element || (e7 + HD_W'(1) == hd_eff);
	assign wp_base   = new_sequence ? '0 : wp_q;
	assign held_base = new_sequence ? '0 : held_q;
	assign held_next = (held_base == CNT_W'(MAX_ROWS)) ? held_base : held_base + CNT_W'(1);
	assign band_win  = {1'b0, window_band} + CNT_W'(1);
	assign win_next  = (band_win > held_next) ? held_next : band_win;
	assign accept    = in_valid && in_ready;
	assign j_last    = ({1'b0, j_q} == win_q - CNT_W'(1));
	assign d_last    = ({1'b0, d_q} == dlen_q - HD_W'(1));
	assign row_sel   = slot_q - j_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:      if (accept && row_end) state_nx = ST_DOT_RUN;
			ST_DOT_RUN:   if (d_last && j_last) state_nx = ST_DOT_WAIT;
			ST_DOT_WAIT:  if (!status.busy) state_nx = ST_EXP_RUN;
			ST_EXP_RUN:   if (j_last) state_nx = ST_EXP_WAIT;
			ST_EXP_WAIT:  if (!status.busy) state_nx = ST_DIV_START;
			ST_DIV_START: state_nx = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (!status.busy) state_nx = ST_WGT_RUN;
			ST_WGT_RUN:   if (j_last) state_nx = ST_WGT_WAIT;
			ST_WGT_WAIT:  if (!status.busy) state_nx = ST_OUT_RUN;
			ST_OUT_RUN:   if (j_last) state_nx = ST_OUT_WAIT;
			ST_OUT_WAIT:  if (!status.busy) state_nx = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (!status.out_full) begin
					state_nx = d_last ? ST_IDLE : ST_OUT_RUN;
				end
			end
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == ST_IDLE);
		cmd              = '0;
		cmd.ld_we        = accept;
		cmd.ld_kv_addr   = {wp_base, e7[DIM_W-1:0]};
		cmd.ld_q_addr    = e7[DIM_W-1:0];
		cmd.rd_kv_addr   = {row_sel, d_q};
		cmd.rd_q_addr    = d_q;
		cmd.rd_scr_addr  = j_q;
		cmd.idx          = j_q;
		cmd.dim          = d_q;
		cmd.dim_last     = d_last;
		cmd.op           = OP_DOT;
		case (state_q)
			ST_DOT_RUN: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_DOT;
				cmd.first = (d_q == '0);
				cmd.last  = d_last;
			end
			ST_EXP_RUN: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_EXP;
				cmd.first = (j_q == '0);
				cmd.last  = j_last;
			end
			ST_WGT_RUN: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_WGT;
				cmd.first = (j_q == '0);
				cmd.last  = j_last;
			end
			ST_OUT_RUN: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_OUT;
				cmd.first = (j_q == '0);
				cmd.last  = j_last;
			end
			ST_DIV_START: cmd.div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			wp_q    <= '0;
			held_q  <= '0;
			slot_q  <= '0;
			dlen_q  <= HD_W'(1);
			win_q   <= CNT_W'(1);
			j_q     <= '0;
			d_q     <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (row_end) begin
							elem_q <= '0;
							wp_q   <= wp_base + ROW_W'(1);
							held_q <= held_next;
							slot_q <= wp_base;
							dlen_q <= e7 + HD_W'(1);
							win_q  <= win_next;
							j_q    <= '0;
							d_q    <= '0;
						end else begin
							elem_q <= e7[DIM_W-1:0] + DIM_W'(1);
							wp_q   <= wp_base;
							held_q <= held_base;
						end
					end
				end
				ST_DOT_RUN: begin
					if (d_last) begin
						d_q <= '0;
						j_q <= j_last ? '0 : j_q + ROW_W'(1);
					end else begin
						d_q <= d_q + DIM_W'(1);
					end
				end
				ST_EXP_RUN, ST_WGT_RUN, ST_OUT_RUN: begin
					j_q <= j_last ? '0 : j_q + ROW_W'(1);
				end
				ST_OUT_HOLD: begin
					if (!status.out_full && !d_last) begin
						d_q <= d_q + DIM_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/cwa_dp.sv
// Datapath: row stores, score scratch, shared multiply-accumulate pipeline,
// exp lookup, reciprocal divider and the result register. Depends on cwa_pkg, cwa_ram.
module cwa_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cwa_pkg::cwa_cmd_t    cmd,
	output cwa_pkg::cwa_status_t status,
	input  cwa_pkg::cwa_in_t     in_item,
	input  logic [15:0]          score_scale,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cwa_pkg::cwa_out_t    out_item
);
	import cwa_pkg::*;

	typedef struct packed {
		logic             v;
		cwa_op_t          op;
		logic             first;
		logic             last;
		logic [ROW_W-1:0] idx;
		logic [DIM_W-1:0] dim;
		logic             dim_last;
	} cwa_tag_t;

	cwa_tag_t t_s1, t_s2, t_s3, t_s4;
	cwa_tag_t t3_nx, t4_nx;

	logic [15:0] q_rd, k_rd, v_rd;
	logic [31:0] scr_rd;
	logic        scr_we;
	logic [ROW_W-1:0] scr_waddr;
	logic [31:0] scr_wdata;

	logic signed [16:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [34:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W+16:0] scaled_s4;
	logic signed [31:0] max_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RCP_W-1:0]   recip_q;

	logic signed [32:0] diff;
	logic [15:0]        ev;
	logic [34:0]        wrnd;
	logic [15:0]        wsat;
	logic signed [31:0] score;
	logic signed [ACC_W:0] ornd;
	logic signed [ACC_W-16:0] ohi;
	logic signed [15:0]    osat;

	logic               div_busy_q;
	logic [5:0]         div_cnt_q;
	logic [SUM_W:0]     rem_q;
	logic [RCP_W-1:0]   quo_q;
	logic [SUM_W+1:0]   rem_sh;
	logic               div_ge;

	logic               out_valid_q;
	cwa_out_t           out_item_q;

	cwa_ram #(.WIDTH(16), .DEPTH(MAX_HEAD_DIM)) u_q_ram (
		.clk(clk), .we(cmd.ld_we), .waddr(cmd.ld_q_addr), .wdata(in_item.q_value),
		.raddr(cmd.rd_q_addr), .rdata(q_rd)
	);
	cwa_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_HEAD_DIM)) u_k_ram (
		.clk(clk), .we(cmd.ld_we), .waddr(cmd.ld_kv_addr), .wdata(in_item.k_value),
		.raddr(cmd.rd_kv_addr), .rdata(k_rd)
	);
	cwa_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_HEAD_DIM)) u_v_ram (
		.clk(clk), .we(cmd.ld_we), .waddr(cmd.ld_kv_addr), .wdata(in_item.v_value),
		.raddr(cmd.rd_kv_addr), .rdata(v_rd)
	);
	cwa_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_scr_ram (
		.clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
		.raddr(cmd.rd_scr_addr), .rdata(scr_rd)
	);

	// Stage 1: exp lookup on the stored score (exp phase).
	assign diff = $signed({max_q[31], max_q}) - $signed({scr_rd[31], scr_rd});
	assign ev   = (diff[32:EXP_STEP_SHIFT] < (33 - EXP_STEP_SHIFT)'(EXP_TABLE_DEPTH))
		? EXP_TABLE[diff[EXP_STEP_SHIFT+TBL_AW-1:EXP_STEP_SHIFT]] : 16'd0;

	always_comb begin
		case (t_s1.op)
			OP_DOT: begin
				mul_a = {q_rd[15], q_rd};
				mul_b = {{2{k_rd[15]}}, k_rd};
			end
			OP_WGT: begin
				mul_a = {1'b0, scr_rd[15:0]};
				mul_b = {1'b0, recip_q};
			end
			OP_OUT: begin
				mul_a = {1'b0, scr_rd[15:0]};
				mul_b = {{2{v_rd[15]}}, v_rd};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Only dot and output items travel past stage 2, and only a finished dot reaches stage 4.
	always_comb begin
		t3_nx   = t_s2;
		t3_nx.v = t_s2.v && (t_s2.op == OP_DOT || t_s2.op == OP_OUT);
		t4_nx   = t_s3;
		t4_nx.v = t_s3.v && t_s3.last && t_s3.op == OP_DOT;
	end

	// Stage 2 weight rounding, stage 3 output rounding, stage 4 score.
	assign wrnd  = prod_s2 + 35'sd32768;
	assign wsat  = (wrnd[34:16] > 19'd65535) ? 16'hFFFF : wrnd[31:16];
	assign score = {scaled_s4[ACC_W+16], scaled_s4[ACC_W+16:28]};
	assign ornd  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(32768);
	assign ohi   = ornd[ACC_W:16];

	always_comb begin
		if (ohi > $signed((ACC_W-15)'(32767))) begin
			osat = 16'sh7FFF;
		end else if (ohi < -$signed((ACC_W-15)'(32768))) begin
			osat = -16'sh8000;
		end else begin
			osat = ornd[31:16];
		end
	end

	always_comb begin
		scr_we    = 1'b0;
		scr_waddr = t_s1.idx;
		scr_wdata = {16'd0, ev};
		if (t_s1.v && t_s1.op == OP_EXP) begin
			scr_we = 1'b1;
		end else if (t_s2.v && t_s2.op == OP_WGT) begin
			scr_we    = 1'b1;
			scr_waddr = t_s2.idx;
			scr_wdata = {16'd0, wsat};
		end else if (t_s4.v) begin
			scr_we    = 1'b1;
			scr_waddr = t_s4.idx;
			scr_wdata = score;
		end
	end

	assign rem_sh = {rem_q, div_cnt_q == 6'd32};
	assign div_ge = rem_sh >= {2'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1        <= '0;
			t_s2        <= '0;
			t_s3        <= '0;
			t_s4        <= '0;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			t_s1 <= '{v: cmd.issue, op: cmd.op, first: cmd.first, last: cmd.last,
				idx: cmd.idx, dim: cmd.dim, dim_last: cmd.dim_last};
			t_s2 <= t_s1;
			t_s3 <= t3_nx;
			t_s4 <= t4_nx;

			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= 6'd32;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - 6'd1;
				if (div_cnt_q == '0) begin
					div_busy_q <= 1'b0;
				end
			end

			if (t_s3.v && t_s3.last && t_s3.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		if (t_s2.v) begin
			acc_q <= t_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (t_s3.v && t_s3.last && t_s3.op == OP_DOT) begin
			scaled_s4 <= acc_q * $signed({1'b0, score_scale});
		end
		if (t_s4.v) begin
			if (t_s4.idx == '0 || score > max_q) begin
				max_q <= score;
			end
		end
		if (t_s1.v && t_s1.op == OP_EXP) begin
			sum_q <= t_s1.first ? SUM_W'(ev) : sum_q + SUM_W'(ev);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_busy_q) begin
			rem_q <= div_ge ? (SUM_W+1)'(rem_sh - {2'b0, sum_q}) : rem_sh[SUM_W:0];
			quo_q <= {quo_q[RCP_W-2:0], div_ge};
			if (div_cnt_q == '0) begin
				recip_q <= {quo_q[RCP_W-2:0], div_ge};
			end
		end
		if (t_s3.v && t_s3.last && t_s3.op == OP_OUT) begin
			out_item_q.out_value   <= osat;
			out_item_q.out_index   <= t_s3.dim;
			out_item_q.last_result <= t_s3.dim_last;
		end
	end

	assign status.busy     = t_s1.v || t_s2.v || t_s3.v || t_s4.v || div_busy_q;
	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign out_item        = out_item_q;

endmodule

// File: rtl/causal_window_attention.sv
// Causal sliding-window attention, one head, fixed point; configuration registers.
// A loaded element gives no result. A row end computes attention over
// window W rows and row length D,
// all through one shared multiply-accumulate pipeline; results leave one per dimension.
// Reset clears pointers and counters and sets the configuration registers to defaults; the row stores stay undefined.
module causal_window_attention (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cwa_pkg::cwa_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cwa_pkg::cwa_out_t out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cwa_pkg::*;

	logic [HD_W-1:0]   head_dim_q;
	logic [BAND_W-1:0] band_q;
	logic [15:0]       scale_q;
	cwa_cmd_t          cmd;
	cwa_status_t       status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_dim_q <= HD_W'(64);
			band_q     <= BAND_W'(511);
			scale_q    <= 16'd8192;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_HEAD_DIM: head_dim_q <= pwdata[HD_W-1:0];
				REG_BAND:     band_q     <= pwdata[BAND_W-1:0];
				REG_SCALE:    scale_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HEAD_DIM: prdata = {{(32-HD_W){1'b0}}, head_dim_q};
			REG_BAND:     prdata = {{(32-BAND_W){1'b0}}, band_q};
			REG_SCALE:    prdata = {16'd0, scale_q};
			default:      prdata = '0;
		endcase
	end

	cwa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.last_element(in_item.last_element), .new_sequence(in_item.new_sequence),
		.head_dim_used(head_dim_q), .window_band(band_q),
		.cmd(cmd), .status(status)
	);

	cwa_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status),
		.in_item(in_item), .score_scale(scale_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule
